### sv/rre_pkg.sv
// Shared types and codes for the RTP relay endpoint forwarder.
// No dependencies; the top level and rre_decide refer to this package by scoped names.
package rre_pkg;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_CREATE = 2'd1,
        OP_MODIFY = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FORWARD = 2'd0,
        ST_DROPPED = 2'd1,
        ST_ACCEPT  = 2'd2,
        ST_REJECT  = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } seq_state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_RELEARN_ALWAYS = 2'd0;
    localparam logic [1:0] CFG_FILTER_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_FILTER_ADDR    = 2'd2;
    localparam logic [1:0] CFG_LOOPBACK       = 2'd3;

    localparam int EP_FIELD_W = 5;

    // One input beat
    typedef struct packed {
        op_t                     opcode;
        logic [EP_FIELD_W-1:0]   endpoint;
        logic [31:0]             src_addr;
        logic [15:0]             src_port;
        logic                    is_rtcp;
        logic [31:0]             remote_addr_in;
        logic [15:0]             remote_port_in;
    } item_t;

    // One result beat
    typedef struct packed {
        status_t     status;
        logic        to_station;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
    } result_t;

    // Configuration registers as seen by the decision logic
    typedef struct packed {
        logic        relearn_always;
        logic        station_filter_enable;
        logic [31:0] station_filter_addr;
        logic        audio_loopback;
    } cfg_t;

    // One row of the connection table
    typedef struct packed {
        logic        in_use;
        logic [31:0] remote_address;
        logic [15:0] remote_rtp_port;
        logic [15:0] remote_rtcp_port;
        logic [15:0] station_rtp_port;
        logic [15:0] station_rtcp_port;
        logic [31:0] station_address;
    } entry_t;

endpackage

### sv/rtp_relay_endpoint_forwarder.sv
// Top level of the RTP relay endpoint forwarder: sequencer, config registers,
// connection table. Uses rre_pkg, rre_ram and rre_decide.
//
// After reset the block clears its connection table, one endpoint per cycle,
// and busy stays high until the clear is done; configuration writes are taken
// throughout. An item is taken when start is high and busy low. For every
// item, at the accepting edge the endpoint row is read from the table RAM
// (separate read and write ports), and in the next cycle the row is updated
// and, if the item is not dropped or rejected, written back. The result
// appears on result with done high for exactly one cycle after that, and
// start can be taken at the edge that ends that cycle; no new item is taken
// during the table read-modify-write of the last one.
// There is no back-pressure on the result side: sample result whenever done
// is high.
module rtp_relay_endpoint_forwarder #(
    parameter int NUM_ENDPOINTS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rre_pkg::item_t   item,
    output logic             done,
    output rre_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam int IDX_W   = $clog2(NUM_ENDPOINTS);
    localparam int CNT_W   = $clog2(NUM_ENDPOINTS + 1);
    localparam int EP_W    = (CNT_W > rre_pkg::EP_FIELD_W) ? CNT_W : rre_pkg::EP_FIELD_W;
    localparam int ENTRY_W = $bits(rre_pkg::entry_t);

    rre_pkg::seq_state_t state_reg, state_next;
    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    rre_pkg::item_t      item_reg;
    rre_pkg::result_t    result_reg;
    logic                done_reg, done_next;
    rre_pkg::cfg_t       cfg_reg;

    logic               accept;
    logic [EP_W-1:0]    in_ep_ext;
    logic [EP_W-1:0]    cur_ep_ext;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    rre_pkg::entry_t    rd_entry;
    rre_pkg::entry_t    upd_entry;
    logic               dec_wr;
    rre_pkg::result_t   dec_result;

    assign busy      = (state_reg != rre_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign in_ep_ext  = EP_W'(item.endpoint);
    assign cur_ep_ext = EP_W'(item_reg.endpoint);
    assign ram_raddr  = in_ep_ext[IDX_W-1:0];
    assign rd_entry   = rre_pkg::entry_t'(ram_rdata);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rre_pkg::CFG_RELEARN_ALWAYS: cfg_reg.relearn_always        <= cfg_data[0];
                rre_pkg::CFG_FILTER_ENABLE:  cfg_reg.station_filter_enable <= cfg_data[0];
                rre_pkg::CFG_FILTER_ADDR:    cfg_reg.station_filter_addr   <= cfg_data;
                rre_pkg::CFG_LOOPBACK:       cfg_reg.audio_loopback        <= cfg_data[0];
                default:                     cfg_reg                       <= cfg_reg;
            endcase
        end
    end

    // connection table
    rre_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_ENDPOINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // per-item decision on the row just read
    rre_decide #(
        .NUM_ENDPOINTS (NUM_ENDPOINTS)
    ) u_decide (
        .item       (item_reg),
        .entry      (rd_entry),
        .cfg        (cfg_reg),
        .wr_en      (dec_wr),
        .entry_next (upd_entry),
        .result     (dec_result)
    );

    // sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rre_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // payload registers: captured item and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == rre_pkg::S_EXEC)
        begin
            result_reg <= dec_result;
        end
    end

    // next state, table write port
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cur_ep_ext[IDX_W-1:0];
        ram_wdata    = ENTRY_W'(upd_entry);
        unique case (state_reg)
            rre_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == IDX_W'(NUM_ENDPOINTS - 1))
                begin
                    state_next = rre_pkg::S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end
            rre_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = rre_pkg::S_EXEC;
                end
            end
            rre_pkg::S_EXEC:
            begin
                ram_we     = dec_wr;
                done_next  = 1'b1;
                state_next = rre_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rre_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == rre_pkg::S_EXEC))
        else $error("result strobe without an executed item");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == rre_pkg::S_EXEC) && busy)
        else $error("accepted item not executed in the next cycle");

    a_no_write_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rre_pkg::S_EXEC && dec_wr) |->
        (dec_result.status == rre_pkg::ST_FORWARD ||
         dec_result.status == rre_pkg::ST_ACCEPT))
        else $error("table written for a dropped or rejected item");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rre_pkg::S_CLEAR) |-> (busy && ram_we && !done_reg))
        else $error("table clear pass not holding off items");

endmodule

### sv/rre_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/rre_decide.sv
// Per-item decision: classifies packets, latches the station side and
// applies create/modify/delete to one table row. Uses rre_pkg.
module rre_decide #(
    parameter int NUM_ENDPOINTS = 32
) (
    input  rre_pkg::item_t   item,
    input  rre_pkg::entry_t  entry,
    input  rre_pkg::cfg_t    cfg,
    output logic             wr_en,
    output rre_pkg::entry_t  entry_next,
    output rre_pkg::result_t result
);

    localparam int CNT_W = $clog2(NUM_ENDPOINTS + 1);
    localparam int EP_W  = (CNT_W > rre_pkg::EP_FIELD_W) ? CNT_W : rre_pkg::EP_FIELD_W;

    logic [EP_W-1:0] ep_ext;
    logic            ep_ok;
    logic            from_net;
    logic            may_latch;
    logic            toward_st;

    assign ep_ext = EP_W'(item.endpoint);
    assign ep_ok  = ep_ext < EP_W'(NUM_ENDPOINTS);

    // packet classification against the stored remote
    assign from_net = (item.src_addr == entry.remote_address) &&
                      ((entry.remote_rtp_port == item.src_port) ||
                       (entry.remote_rtcp_port == item.src_port));

    // station latch: not yet learned (rtp port zero) or relearn, and filter
    assign may_latch = !from_net &&
                       ((entry.station_rtp_port == 16'd0) || cfg.relearn_always) &&
                       (!cfg.station_filter_enable ||
                        (item.src_addr == cfg.station_filter_addr));

    assign toward_st = from_net ^ cfg.audio_loopback;

    always_comb
    begin
        wr_en             = 1'b0;
        entry_next        = entry;
        result.status     = rre_pkg::ST_REJECT;
        result.to_station = 1'b0;
        result.dest_addr  = '0;
        result.dest_port  = '0;
        unique case (item.opcode)
            rre_pkg::OP_PACKET:
            begin
                if (!ep_ok || !entry.in_use)
                begin
                    result.status = rre_pkg::ST_DROPPED;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (may_latch)
                    begin
                        if (item.is_rtcp)
                        begin
                            entry_next.station_rtcp_port = item.src_port;
                        end
                        else
                        begin
                            entry_next.station_rtp_port = item.src_port;
                        end
                        entry_next.station_address = item.src_addr;
                    end
                    result.status     = rre_pkg::ST_FORWARD;
                    result.to_station = toward_st;
                    if (toward_st)
                    begin
                        result.dest_addr = entry_next.station_address;
                        result.dest_port = item.is_rtcp ? entry_next.station_rtcp_port
                                                        : entry_next.station_rtp_port;
                    end
                    else
                    begin
                        result.dest_addr = entry.remote_address;
                        result.dest_port = item.is_rtcp ? entry.remote_rtcp_port
                                                        : entry.remote_rtp_port;
                    end
                end
            end
            rre_pkg::OP_CREATE:
            begin
                if (ep_ok && !entry.in_use)
                begin
                    wr_en                        = 1'b1;
                    entry_next.in_use            = 1'b1;
                    entry_next.remote_address    = '0;
                    entry_next.remote_rtp_port   = '0;
                    entry_next.remote_rtcp_port  = '0;
                    entry_next.station_rtp_port  = '0;
                    entry_next.station_rtcp_port = '0;
                    result.status                = rre_pkg::ST_ACCEPT;
                end
            end
            rre_pkg::OP_MODIFY:
            begin
                if (ep_ok && entry.in_use)
                begin
                    wr_en                       = 1'b1;
                    entry_next.remote_address   = item.remote_addr_in;
                    entry_next.remote_rtp_port  = item.remote_port_in;
                    entry_next.remote_rtcp_port = item.remote_port_in + 16'd1;
                    result.status               = rre_pkg::ST_ACCEPT;
                end
            end
            rre_pkg::OP_DELETE:
            begin
                if (ep_ok && entry.in_use)
                begin
                    wr_en                        = 1'b1;
                    entry_next.in_use            = 1'b0;
                    entry_next.remote_rtp_port   = '0;
                    entry_next.remote_rtcp_port  = '0;
                    entry_next.station_rtp_port  = '0;
                    entry_next.station_rtcp_port = '0;
                    result.status                = rre_pkg::ST_ACCEPT;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule
